### rtl/salru_pkg.sv
// salru_pkg: shared types, codes and helpers for the set-associative LRU tag store.
// Used by salru_store and set_assoc_cache_lru_sim_core; depends on nothing.
package salru_pkg;

  localparam int MAX_SET_BITS_DEF = 6;
  localparam int MAX_WAYS_DEF     = 8;
  localparam int STAMP_W          = 64;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 5;

  localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

  localparam logic [CFG_IDX_W-1:0] REG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = 2'd2;

  localparam logic [1:0] OP_MODIFY = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [1:0] OUT_HIT   = 2'd0;
  localparam logic [1:0] OUT_FILL  = 2'd1;
  localparam logic [1:0] OUT_EVICT = 2'd2;
  localparam logic [1:0] OUT_NONE  = 2'd3;

  // stamp holds the item count at the line's last touch
  typedef struct packed {
    logic               valid;
    logic [31:0]        tag;
    logic [STAMP_W-1:0] stamp;
  } line_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == ALL_ONES) ? v : v + 32'd1;
  endfunction

endpackage

### rtl/set_assoc_cache_lru_sim_core.sv
// set_assoc_cache_lru_sim_core: tag store of a set-associative cache with LRU replacement.
// Instantiates salru_store; uses salru_pkg.
//
// Channels: cfg (valid/ready, always ready) writes set_bits, ways, block_bits; the user
// writes them only while idle, the block does not enforce it. Input beat: opcode and
// address. Output beat: outcome, second_hit and the saturating hit, miss and eviction
// counts after the item. One sequencer walks the ways of the addressed set through the
// single read port of the line memory: a read and a compare/age check per way examined,
// stopping at the first hit; a miss then fills or evicts, and every item ends by posting
// the result. An unused opcode goes straight to posting.
// A modify costs the same as a single access; its second access is a guaranteed hit.
// LRU age is kept as the item count at the last touch; the age is the 64-bit difference
// to the current count, saturated to 32 bits.
// Reset: counts clear, set_bits/ways/block_bits reset to 1/1/0; then a sweep over all
// (2^MAX_SET_BITS)*MAX_WAYS lines (512 at default) clears the valid bits; no input beat
// is taken meanwhile, cfg is. Output stall: the result sits in an output register; the
// next item is accepted and worked on, and its result waits until the held beat is taken.
module set_assoc_cache_lru_sim_core #(
  parameter int MAX_SET_BITS = salru_pkg::MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = salru_pkg::MAX_WAYS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [salru_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [salru_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       opcode_i,
  input  logic [31:0]                      address_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [1:0]                       outcome_o,
  output logic                             second_hit_o,
  output logic [31:0]                      hit_count_o,
  output logic [31:0]                      miss_count_o,
  output logic [31:0]                      eviction_count_o
);

  localparam int DEPTH = (1 << MAX_SET_BITS) * MAX_WAYS;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int WAY_W = $clog2(MAX_WAYS + 1);
  localparam int SB_W  = $clog2(MAX_SET_BITS + 1);

  typedef enum logic [2:0] {ST_IDLE, ST_READ, ST_EVAL, ST_FILL, ST_DONE} state_e;

  state_e                            state_q;
  logic [2:0]                        set_bits_q;
  logic [3:0]                        ways_q;
  logic [4:0]                        block_bits_q;
  logic [1:0]                        op_q;
  logic [MAX_SET_BITS-1:0]           set_q;
  logic [31:0]                       tag_q;
  logic [WAY_W-1:0]                  e_q;
  logic [WAY_W-1:0]                  way_q;
  logic                              inv_found_q;
  logic [WAY_W-1:0]                  inv_way_q;
  logic [WAY_W-1:0]                  victim_q;
  logic [31:0]                       oldest_q;
  logic [1:0]                        outcome_q;
  logic [salru_pkg::STAMP_W-1:0]     now_q;
  logic [31:0]                       hits_q;
  logic [31:0]                       misses_q;
  logic [31:0]                       evicts_q;
  logic                              out_valid_q;
  logic [1:0]                        out_outcome_q;
  logic                              out_second_q;
  logic [31:0]                       out_hits_q;
  logic [31:0]                       out_misses_q;
  logic [31:0]                       out_evicts_q;

  logic [SB_W-1:0]                   s_eff;
  logic [WAY_W-1:0]                  e_eff;
  logic [31:0]                       set_full;
  logic [5:0]                        shift_amt;
  logic [31:0]                       tag_sel;
  salru_pkg::line_t                  rd_line;
  salru_pkg::line_t                  wr_line;
  logic                              hit;
  logic [salru_pkg::STAMP_W-1:0]     diff;
  logic [31:0]                       age;
  logic [WAY_W-1:0]                  acc_way;
  logic [IDX_W-1:0]                  mem_idx;
  logic                              rd_en;
  logic                              wr_en;
  logic                              clr_busy;
  logic                              out_free;
  logic                              last_way;
  logic [31:0]                       hits_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   <= 3'd1;
      ways_q       <= 4'd1;
      block_bits_q <= 5'd0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        salru_pkg::REG_SET_BITS:   set_bits_q   <= cfg_data_i[2:0];
        salru_pkg::REG_WAYS:       ways_q       <= cfg_data_i[3:0];
        salru_pkg::REG_BLOCK_BITS: block_bits_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (set_bits_q == 3'd0) begin
      s_eff = SB_W'(1);
    end else if (int'(set_bits_q) > MAX_SET_BITS) begin
      s_eff = SB_W'(MAX_SET_BITS);
    end else begin
      s_eff = SB_W'(set_bits_q);
    end
    if (ways_q == 4'd0) begin
      e_eff = WAY_W'(1);
    end else if (int'(ways_q) > MAX_WAYS) begin
      e_eff = WAY_W'(MAX_WAYS);
    end else begin
      e_eff = WAY_W'(ways_q);
    end
    set_full  = (address_i >> block_bits_q) & ((32'd1 << s_eff) - 32'd1);
    shift_amt = 6'(block_bits_q) + 6'(s_eff);
    tag_sel   = (shift_amt >= 6'd32) ? 32'd0 : (address_i >> shift_amt[4:0]);
  end

  assign hit  = rd_line.valid && (rd_line.tag == tag_q);
  assign diff = now_q - rd_line.stamp;
  assign age  = (|diff[salru_pkg::STAMP_W-1:32]) ? salru_pkg::ALL_ONES : diff[31:0];

  assign acc_way = (state_q == ST_FILL) ? (inv_found_q ? inv_way_q : victim_q) : way_q;
  assign mem_idx = IDX_W'(set_q) * IDX_W'(MAX_WAYS) + IDX_W'(acc_way);

  assign wr_line.valid = 1'b1;
  assign wr_line.tag   = tag_q;
  assign wr_line.stamp = now_q;

  assign rd_en = (state_q == ST_READ);
  assign wr_en = ((state_q == ST_EVAL) && hit) || (state_q == ST_FILL);

  assign in_ready_o = (state_q == ST_IDLE) && !clr_busy;
  assign out_free   = !out_valid_q || out_ready_i;
  assign last_way   = (way_q == e_q - WAY_W'(1));
  assign hits_next  = (op_q == salru_pkg::OP_MODIFY) ? salru_pkg::sat_inc(hits_q) : hits_q;

  salru_store #(
    .MAX_SET_BITS(MAX_SET_BITS),
    .MAX_WAYS    (MAX_WAYS)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_idx_i  (mem_idx),
    .rd_line_o (rd_line),
    .wr_en_i   (wr_en),
    .wr_idx_i  (mem_idx),
    .wr_line_i (wr_line),
    .clr_busy_o(clr_busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      op_q          <= salru_pkg::OP_NONE;
      set_q         <= '0;
      tag_q         <= '0;
      e_q           <= WAY_W'(1);
      way_q         <= '0;
      inv_found_q   <= 1'b0;
      inv_way_q     <= '0;
      victim_q      <= '0;
      oldest_q      <= '0;
      outcome_q     <= salru_pkg::OUT_NONE;
      now_q         <= '0;
      hits_q        <= '0;
      misses_q      <= '0;
      evicts_q      <= '0;
      out_valid_q   <= 1'b0;
      out_outcome_q <= salru_pkg::OUT_NONE;
      out_second_q  <= 1'b0;
      out_hits_q    <= '0;
      out_misses_q  <= '0;
      out_evicts_q  <= '0;
    end else begin
      // in ST_DONE the held beat is either kept or replaced below
      if (out_valid_q && out_ready_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            op_q        <= opcode_i;
            set_q       <= set_full[MAX_SET_BITS-1:0];
            tag_q       <= tag_sel;
            e_q         <= e_eff;
            way_q       <= '0;
            inv_found_q <= 1'b0;
            inv_way_q   <= '0;
            victim_q    <= '0;
            oldest_q    <= '0;
            outcome_q   <= salru_pkg::OUT_NONE;
            state_q     <= (opcode_i == salru_pkg::OP_NONE) ? ST_DONE : ST_READ;
          end
        end
        ST_READ: begin
          state_q <= ST_EVAL;
        end
        ST_EVAL: begin
          if (hit) begin
            hits_q    <= salru_pkg::sat_inc(hits_q);
            outcome_q <= salru_pkg::OUT_HIT;
            state_q   <= ST_DONE;
          end else begin
            if (!rd_line.valid && !inv_found_q) begin
              inv_found_q <= 1'b1;
              inv_way_q   <= way_q;
            end
            if (rd_line.valid && (age > oldest_q)) begin
              oldest_q <= age;
              victim_q <= way_q;
            end
            if (last_way) begin
              state_q <= ST_FILL;
            end else begin
              way_q   <= way_q + WAY_W'(1);
              state_q <= ST_READ;
            end
          end
        end
        ST_FILL: begin
          misses_q <= salru_pkg::sat_inc(misses_q);
          if (inv_found_q) begin
            outcome_q <= salru_pkg::OUT_FILL;
          end else begin
            evicts_q  <= salru_pkg::sat_inc(evicts_q);
            outcome_q <= salru_pkg::OUT_EVICT;
          end
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            out_outcome_q <= outcome_q;
            out_second_q  <= (op_q == salru_pkg::OP_MODIFY);
            hits_q        <= hits_next;
            out_hits_q    <= hits_next;
            out_misses_q  <= misses_q;
            out_evicts_q  <= evicts_q;
            now_q         <= now_q + salru_pkg::STAMP_W'(1);
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign outcome_o        = out_outcome_q;
  assign second_hit_o     = out_second_q;
  assign hit_count_o      = out_hits_q;
  assign miss_count_o     = out_misses_q;
  assign eviction_count_o = out_evicts_q;

endmodule

### rtl/salru_store.sv
// salru_store: line memory (valid, tag, stamp) with one read and one write port.
// Clears every valid bit in a sweep after reset. Depends on salru_pkg.
module salru_store #(
  parameter int MAX_SET_BITS = salru_pkg::MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = salru_pkg::MAX_WAYS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    rd_en_i,
  input  logic [$clog2((1 << MAX_SET_BITS) * MAX_WAYS)-1:0] rd_idx_i,
  output salru_pkg::line_t                        rd_line_o,
  input  logic                                    wr_en_i,
  input  logic [$clog2((1 << MAX_SET_BITS) * MAX_WAYS)-1:0] wr_idx_i,
  input  salru_pkg::line_t                        wr_line_i,
  output logic                                    clr_busy_o
);

  localparam int DEPTH = (1 << MAX_SET_BITS) * MAX_WAYS;
  localparam int IDX_W = $clog2(DEPTH);

  salru_pkg::line_t mem [DEPTH];
  salru_pkg::line_t rd_q;
  logic             clr_q;
  logic [IDX_W-1:0] clr_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_idx_q <= '0;
    end else if (clr_q) begin
      if (clr_idx_q == IDX_W'(DEPTH - 1)) begin
        clr_q <= 1'b0;
      end
      clr_idx_q <= clr_idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem[clr_idx_q] <= '0;
    end else if (wr_en_i) begin
      mem[wr_idx_i] <= wr_line_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_idx_i];
    end
  end

  assign rd_line_o  = rd_q;
  assign clr_busy_o = clr_q;

endmodule
